// ===== rtl/core/pwm_angle_sensor_conditioner_assert.svh =====
// Assertion macros for the PWM angle sensor conditioner.
`ifndef PWM_ANGLE_SENSOR_CONDITIONER_ASSERT_SVH
`define PWM_ANGLE_SENSOR_CONDITIONER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define PASC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define PASC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pasc_pkg.sv =====
// Shared types, widths and constants of the PWM angle sensor conditioner.
package pasc_pkg;

  localparam int SENSOR_RESOLUTION = 4096;
  localparam int FRAME_CLOCKS      = 4119;
  localparam int ZERO_CLOCKS       = 16;

  localparam int CAP_W    = 16;
  localparam int MODE_W   = 2;
  localparam int LIM_W    = 12;
  localparam int ALPHA_W  = 16;
  localparam int COEF_W   = 48;
  localparam int AL_W     = 14;
  localparam int ANG_W    = 22;

  localparam int HALF_RES  = SENSOR_RESOLUTION / 2;
  localparam int CNT_MAX   = FRAME_CLOCKS - ZERO_CLOCKS;
  localparam int CNT_W     = $clog2(CNT_MAX + 1);
  localparam int DEN_W     = CAP_W + 1;
  localparam int NUM_W     = $clog2((1 << CAP_W) * FRAME_CLOCKS + 1);
  localparam int RAW_SCALE = 2 * 360 * 256;
  localparam int RAW_SHIFT = $clog2(2 * SENSOR_RESOLUTION);

  localparam int MAC_A_W      = 25;
  localparam int MAC_B_W      = 24;
  localparam int MAC_P_W      = MAC_A_W + MAC_B_W;
  localparam int MAC_ACC_W    = 72;
  localparam int MAC_HI_SHIFT = 24;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_ALIGN_MODE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_EXTENSION_LIMIT = 3'd1;
  localparam logic [IDX_W-1:0] REG_FILTER_ALPHA    = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_CUBIC      = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_SQUARE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_LINEAR     = 3'd5;
  localparam logic [IDX_W-1:0] REG_COEF_OFFSET     = 3'd6;

  localparam logic [MODE_W-1:0] ALIGN_CNT_MINUS_LIM = 2'd0;
  localparam logic [MODE_W-1:0] ALIGN_LIM_MINUS_CNT = 2'd1;
  localparam logic [MODE_W-1:0] ALIGN_FWD_WRAP      = 2'd2;
  localparam logic [MODE_W-1:0] ALIGN_REV_WRAP      = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]         align_mode;
    logic [LIM_W-1:0]          extension_limit;
    logic [ALPHA_W-1:0]        filter_alpha;
    logic signed [COEF_W-1:0]  coef_cubic;
    logic signed [COEF_W-1:0]  coef_square;
    logic signed [COEF_W-1:0]  coef_linear;
    logic signed [COEF_W-1:0]  coef_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    align_mode:      ALIGN_LIM_MINUS_CNT,
    extension_limit: 12'd3012,
    filter_alpha:    16'd52429,
    coef_cubic:      -48'sd551988,
    coef_square:     -48'sd222739060,
    coef_linear:     48'sd30016666694,
    coef_offset:     -48'sd1539316278
  };

  typedef struct packed {
    logic issue;
    logic clear;
    logic shift_hi;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/core/pasc_regs.sv =====
// APB configuration register file of the PWM angle sensor conditioner.
module pasc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pasc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pasc_pkg::DATA_W-1:0]   pwdata,
  output logic [pasc_pkg::DATA_W-1:0]   prdata,
  output pasc_pkg::cfg_t                cfg
);

  localparam int ADDR_W = pasc_pkg::ADDR_W;
  localparam int DATA_W = pasc_pkg::DATA_W;
  localparam int COEF_W = pasc_pkg::COEF_W;
  localparam int IDX_W  = pasc_pkg::IDX_W;

  pasc_pkg::cfg_t           cfg_r;
  logic                     wr_en;
  logic [IDX_W-1:0]         idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pasc_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        pasc_pkg::REG_ALIGN_MODE: begin
          cfg_r.align_mode <= pwdata[pasc_pkg::MODE_W-1:0];
        end
        pasc_pkg::REG_EXTENSION_LIMIT: begin
          cfg_r.extension_limit <= pwdata[pasc_pkg::LIM_W-1:0];
        end
        pasc_pkg::REG_FILTER_ALPHA: begin
          cfg_r.filter_alpha <= pwdata[pasc_pkg::ALPHA_W-1:0];
        end
        pasc_pkg::REG_COEF_CUBIC: begin
          cfg_r.coef_cubic <= $signed(pwdata[COEF_W-1:0]);
        end
        pasc_pkg::REG_COEF_SQUARE: begin
          cfg_r.coef_square <= $signed(pwdata[COEF_W-1:0]);
        end
        pasc_pkg::REG_COEF_LINEAR: begin
          cfg_r.coef_linear <= $signed(pwdata[COEF_W-1:0]);
        end
        pasc_pkg::REG_COEF_OFFSET: begin
          cfg_r.coef_offset <= $signed(pwdata[COEF_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pasc_pkg::REG_ALIGN_MODE: begin
        prdata = DATA_W'(cfg_r.align_mode);
      end
      pasc_pkg::REG_EXTENSION_LIMIT: begin
        prdata = DATA_W'(cfg_r.extension_limit);
      end
      pasc_pkg::REG_FILTER_ALPHA: begin
        prdata = DATA_W'(cfg_r.filter_alpha);
      end
      pasc_pkg::REG_COEF_CUBIC: begin
        prdata = {{(DATA_W-COEF_W){cfg_r.coef_cubic[COEF_W-1]}}, cfg_r.coef_cubic};
      end
      pasc_pkg::REG_COEF_SQUARE: begin
        prdata = {{(DATA_W-COEF_W){cfg_r.coef_square[COEF_W-1]}}, cfg_r.coef_square};
      end
      pasc_pkg::REG_COEF_LINEAR: begin
        prdata = {{(DATA_W-COEF_W){cfg_r.coef_linear[COEF_W-1]}}, cfg_r.coef_linear};
      end
      pasc_pkg::REG_COEF_OFFSET: begin
        prdata = {{(DATA_W-COEF_W){cfg_r.coef_offset[COEF_W-1]}}, cfg_r.coef_offset};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/pasc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module pasc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pasc_pkg::NUM_W-1:0]   numer,
  input  logic [pasc_pkg::DEN_W-1:0]   denom,
  output pasc_pkg::div_sts_t           sts,
  output logic [pasc_pkg::NUM_W-1:0]   quot
);

  localparam int NUM_W = pasc_pkg::NUM_W;
  localparam int DEN_W = pasc_pkg::DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  assign rem_sh = {rem_r, quot_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = ~diff[DEN_W+1];

  assign quot     = quot_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= numer;
      rem_r  <= '0;
      den_r  <= denom;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot_r <= {quot_r[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/pasc_mac.sv =====
// Shared signed multiply-accumulate unit with a registered product.
module pasc_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pasc_pkg::mac_ctl_t                    ctl,
  input  logic signed [pasc_pkg::MAC_A_W-1:0]   op_a,
  input  logic signed [pasc_pkg::MAC_B_W-1:0]   op_b,
  output logic signed [pasc_pkg::MAC_ACC_W-1:0] acc
);

  localparam int P_W   = pasc_pkg::MAC_P_W;
  localparam int ACC_W = pasc_pkg::MAC_ACC_W;

  pasc_pkg::mac_ctl_t      ctl_r;
  logic signed [P_W-1:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] base;

  assign prod_ext = ACC_W'(prod_r);
  assign addend   = ctl_r.shift_hi ? (prod_ext <<< pasc_pkg::MAC_HI_SHIFT) : prod_ext;
  assign base     = ctl_r.clear ? '0 : acc_r;
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctl_r.issue) begin
      acc_r <= base + addend;
    end
  end

endmodule

// ===== rtl/core/pwm_angle_sensor_conditioner.sv =====
// Top level and sequencer of the PWM angle sensor conditioner.
//
//  channel   direction  handshake              payload
//  in_       input      in_valid / in_ready    in_period_count, in_high_count
//  out_      output     out_valid / out_ready  aligned_count, filtered/compensated angle
//  config    APB        psel, penable, pready  paddr, pwdata, prdata (64 bit, 8*index)
//
// The 29-step divider and the ten products through the one shared multiplier set the
// time from one input to its result and to the next input.
// in_ready is high only while the sequencer is idle.
// A finished result waits in the output register; the sequencer holds in its
// last step while that register is still full.
// rst_n is synchronous; it clears control state and the filter history.
module pwm_angle_sensor_conditioner (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pasc_pkg::CAP_W-1:0]           in_period_count,
  input  logic [pasc_pkg::CAP_W-1:0]           in_high_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pasc_pkg::AL_W-1:0]     out_aligned_count,
  output logic signed [pasc_pkg::ANG_W-1:0]    out_filtered_angle,
  output logic signed [pasc_pkg::ANG_W-1:0]    out_compensated_angle,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pasc_pkg::ADDR_W-1:0]          paddr,
  input  logic [pasc_pkg::DATA_W-1:0]          pwdata,
  output logic [pasc_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  localparam int CAP_W   = pasc_pkg::CAP_W;
  localparam int A_W     = pasc_pkg::MAC_A_W;
  localparam int B_W     = pasc_pkg::MAC_B_W;
  localparam int ACC_W   = pasc_pkg::MAC_ACC_W;
  localparam int NUM_W   = pasc_pkg::NUM_W;
  localparam int DEN_W   = pasc_pkg::DEN_W;
  localparam int CNT_W   = pasc_pkg::CNT_W;
  localparam int AL_W    = pasc_pkg::AL_W;
  localparam int ANG_W   = pasc_pkg::ANG_W;
  localparam int COEF_W  = pasc_pkg::COEF_W;
  localparam int ALPHA_W = pasc_pkg::ALPHA_W;
  localparam int CALC_W  = 16;
  localparam int RND_W   = 64;
  localparam int Q8_SHIFT   = 8;
  localparam int FLT_SHIFT  = ALPHA_W + 1;
  localparam int CORR_SHIFT = 32;
  localparam int E_W        = COEF_W + 1 - CORR_SHIFT;

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_CNT_MUL   = 5'd1;
  localparam logic [4:0] ST_CNT_WAIT  = 5'd2;
  localparam logic [4:0] ST_DIV_GO    = 5'd3;
  localparam logic [4:0] ST_DIV_RUN   = 5'd4;
  localparam logic [4:0] ST_ALIGN     = 5'd5;
  localparam logic [4:0] ST_RAW_MUL   = 5'd6;
  localparam logic [4:0] ST_RAW_WAIT  = 5'd7;
  localparam logic [4:0] ST_RAW_TAKE  = 5'd8;
  localparam logic [4:0] ST_FLT_MUL_A = 5'd9;
  localparam logic [4:0] ST_FLT_MUL_B = 5'd10;
  localparam logic [4:0] ST_FLT_WAIT  = 5'd11;
  localparam logic [4:0] ST_FLT_TAKE  = 5'd12;
  localparam logic [4:0] ST_HRN_LO    = 5'd13;
  localparam logic [4:0] ST_HRN_HI    = 5'd14;
  localparam logic [4:0] ST_HRN_WAIT  = 5'd15;
  localparam logic [4:0] ST_HRN_RND   = 5'd16;
  localparam logic [4:0] ST_HRN_ADD   = 5'd17;
  localparam logic [4:0] ST_OUT       = 5'd18;

  localparam logic [1:0] HRN_SQUARE = 2'd0;
  localparam logic [1:0] HRN_LINEAR = 2'd1;
  localparam logic [1:0] HRN_OFFSET = 2'd2;

  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (v[ACC_W-1:ANG_W-1] == {(ACC_W-ANG_W+1){v[ANG_W-1]}});
    if (fits) begin
      return v[ANG_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(ANG_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ANG_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [RND_W-1:0] v);
    logic fits;
    fits = (v[RND_W-1:COEF_W-1] == {(RND_W-COEF_W+1){v[COEF_W-1]}});
    if (fits) begin
      return v[COEF_W-1:0];
    end else if (v[RND_W-1]) begin
      return {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COEF_W-1){1'b1}}};
    end
  endfunction

  logic [4:0]                state_r;
  logic [4:0]                state_nxt;
  logic [CAP_W-1:0]          period_r;
  logic [CAP_W-1:0]          high_r;
  logic signed [AL_W-1:0]    al_r;
  logic signed [AL_W-1:0]    al_nxt;
  logic signed [ANG_W-1:0]   raw_r;
  logic signed [ANG_W-1:0]   raw_nxt;
  logic signed [ANG_W-1:0]   filt_r;
  logic signed [ANG_W-1:0]   filt_nxt;
  logic signed [ANG_W-1:0]   prev_raw_r;
  logic signed [ANG_W-1:0]   prev_flt_r;
  logic signed [COEF_W-1:0]  hacc_r;
  logic signed [COEF_W-1:0]  hacc_nxt;
  logic signed [RND_W-1:0]   rnd_r;
  logic signed [RND_W-1:0]   rnd_nxt;
  logic [1:0]                hrn_cnt_r;
  logic                      out_valid_r;
  logic signed [AL_W-1:0]    out_al_r;
  logic signed [ANG_W-1:0]   out_flt_r;
  logic signed [ANG_W-1:0]   out_comp_r;
  logic signed [ANG_W-1:0]   comp_nxt;
  logic                      out_free;

  pasc_pkg::cfg_t            cfg;
  pasc_pkg::mac_ctl_t        mac_ctl;
  logic signed [A_W-1:0]     mac_a;
  logic signed [B_W-1:0]     mac_b;
  logic signed [ACC_W-1:0]   mac_acc;
  logic                      div_start;
  pasc_pkg::div_sts_t        div_sts;
  logic [NUM_W-1:0]          div_quot;
  logic [DEN_W-1:0]          div_den;

  logic [CAP_W:0]            high_inc;
  logic [ALPHA_W:0]          alpha_c;
  logic signed [ANG_W:0]     raw_pair;
  logic [NUM_W-1:0]          q_off;
  logic [CNT_W-1:0]          cnt;
  logic signed [CALC_W-1:0]  cnt_s;
  logic signed [CALC_W-1:0]  lim_s;
  logic signed [CALC_W-1:0]  res_s;
  logic signed [CALC_W-1:0]  al_wide;
  logic signed [ACC_W-1:0]   raw_sum;
  logic signed [ACC_W-1:0]   flt_sum;
  logic signed [ACC_W-1:0]   q8_sum;
  logic signed [COEF_W-1:0]  coef_sel;
  logic signed [RND_W-1:0]   hrn_sum;
  logic signed [COEF_W:0]    corr_sum;
  logic signed [E_W-1:0]     corr;
  logic signed [ANG_W:0]     comp_sum;

  pasc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  pasc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (mac_acc[NUM_W-1:0]),
    .denom (div_den),
    .sts   (div_sts),
    .quot  (div_quot)
  );

  pasc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc)
  );

  assign pready    = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = ~out_valid_r | out_ready;
  assign div_start = (state_r == ST_DIV_GO);
  assign div_den   = {1'b0, period_r} + DEN_W'(1);

  assign out_aligned_count     = out_al_r;
  assign out_filtered_angle    = out_flt_r;
  assign out_compensated_angle = out_comp_r;

  assign high_inc = {1'b0, high_r} + (CAP_W+1)'(1);
  assign alpha_c  = {1'b1, {ALPHA_W{1'b0}}} - {1'b0, cfg.filter_alpha};
  assign raw_pair = (ANG_W+1)'(raw_r) + (ANG_W+1)'(prev_raw_r);

  // multiplier operand select
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_r)
      ST_CNT_MUL: begin
        mac_ctl = '{issue: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a   = $signed(A_W'(high_inc));
        mac_b   = $signed(B_W'(pasc_pkg::FRAME_CLOCKS));
      end
      ST_RAW_MUL: begin
        mac_ctl = '{issue: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a   = A_W'(al_r);
        mac_b   = $signed(B_W'(pasc_pkg::RAW_SCALE));
      end
      ST_FLT_MUL_A: begin
        mac_ctl = '{issue: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a   = $signed(A_W'({cfg.filter_alpha, 1'b0}));
        mac_b   = B_W'(prev_flt_r);
      end
      ST_FLT_MUL_B: begin
        mac_ctl = '{issue: 1'b1, clear: 1'b0, shift_hi: 1'b0};
        mac_a   = $signed(A_W'(alpha_c));
        mac_b   = B_W'(raw_pair);
      end
      ST_HRN_LO: begin
        mac_ctl = '{issue: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a   = $signed(A_W'(hacc_r[pasc_pkg::MAC_HI_SHIFT-1:0]));
        mac_b   = B_W'(filt_r);
      end
      ST_HRN_HI: begin
        mac_ctl = '{issue: 1'b1, clear: 1'b0, shift_hi: 1'b1};
        mac_a   = A_W'($signed(hacc_r[COEF_W-1:pasc_pkg::MAC_HI_SHIFT]));
        mac_b   = B_W'(filt_r);
      end
      default: begin
      end
    endcase
  end

  // count saturation and alignment
  always_comb begin
    q_off = div_quot - NUM_W'(pasc_pkg::ZERO_CLOCKS);
    if (div_quot < NUM_W'(pasc_pkg::ZERO_CLOCKS)) begin
      cnt = '0;
    end else if (div_quot > NUM_W'(pasc_pkg::FRAME_CLOCKS)) begin
      cnt = CNT_W'(pasc_pkg::CNT_MAX);
    end else begin
      cnt = q_off[CNT_W-1:0];
    end
    cnt_s = $signed(CALC_W'(cnt));
    lim_s = $signed(CALC_W'(cfg.extension_limit));
    res_s = $signed(CALC_W'(pasc_pkg::SENSOR_RESOLUTION));
    unique case (cfg.align_mode)
      pasc_pkg::ALIGN_CNT_MINUS_LIM: begin
        al_wide = cnt_s - lim_s;
      end
      pasc_pkg::ALIGN_LIM_MINUS_CNT: begin
        al_wide = lim_s - cnt_s;
      end
      pasc_pkg::ALIGN_FWD_WRAP: begin
        if (cnt_s <= $signed(CALC_W'(pasc_pkg::HALF_RES))) begin
          al_wide = cnt_s + res_s - lim_s;
        end else begin
          al_wide = cnt_s - lim_s;
        end
      end
      pasc_pkg::ALIGN_REV_WRAP: begin
        if (cnt_s <= $signed(CALC_W'(pasc_pkg::HALF_RES))) begin
          al_wide = lim_s - cnt_s;
        end else begin
          al_wide = res_s + lim_s - cnt_s;
        end
      end
      default: begin
        al_wide = '0;
      end
    endcase
    if (al_wide[CALC_W-1:AL_W-1] == {(CALC_W-AL_W+1){al_wide[AL_W-1]}}) begin
      al_nxt = al_wide[AL_W-1:0];
    end else if (al_wide[CALC_W-1]) begin
      al_nxt = {1'b1, {(AL_W-1){1'b0}}};
    end else begin
      al_nxt = {1'b0, {(AL_W-1){1'b1}}};
    end
  end

  // rounding, filter, Horner and correction arithmetic
  always_comb begin
    raw_sum  = mac_acc + $signed(ACC_W'(pasc_pkg::SENSOR_RESOLUTION));
    raw_nxt  = sat_ang(raw_sum >>> pasc_pkg::RAW_SHIFT);
    flt_sum  = mac_acc + $signed(ACC_W'(1 << ALPHA_W));
    filt_nxt = sat_ang(flt_sum >>> FLT_SHIFT);
    q8_sum   = mac_acc + $signed(ACC_W'(1 << (Q8_SHIFT - 1)));
    rnd_nxt  = RND_W'(q8_sum >>> Q8_SHIFT);
    unique case (hrn_cnt_r)
      HRN_SQUARE: coef_sel = cfg.coef_square;
      HRN_LINEAR: coef_sel = cfg.coef_linear;
      default:    coef_sel = cfg.coef_offset;
    endcase
    hrn_sum  = rnd_r + RND_W'(coef_sel);
    hacc_nxt = sat_coef(hrn_sum);
    corr_sum = (COEF_W+1)'(hacc_r)
             + $signed({{(COEF_W-CORR_SHIFT+1){1'b0}}, 1'b1, {(CORR_SHIFT-1){1'b0}}});
    corr     = corr_sum[COEF_W:CORR_SHIFT];
    comp_sum = (ANG_W+1)'(filt_r) + (ANG_W+1)'(corr);
    if (comp_sum[ANG_W] == comp_sum[ANG_W-1]) begin
      comp_nxt = comp_sum[ANG_W-1:0];
    end else if (comp_sum[ANG_W]) begin
      comp_nxt = {1'b1, {(ANG_W-1){1'b0}}};
    end else begin
      comp_nxt = {1'b0, {(ANG_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_CNT_MUL;
      ST_CNT_MUL:   state_nxt = ST_CNT_WAIT;
      ST_CNT_WAIT:  state_nxt = ST_DIV_GO;
      ST_DIV_GO:    state_nxt = ST_DIV_RUN;
      ST_DIV_RUN:   if (div_sts.done) state_nxt = ST_ALIGN;
      ST_ALIGN:     state_nxt = ST_RAW_MUL;
      ST_RAW_MUL:   state_nxt = ST_RAW_WAIT;
      ST_RAW_WAIT:  state_nxt = ST_RAW_TAKE;
      ST_RAW_TAKE:  state_nxt = ST_FLT_MUL_A;
      ST_FLT_MUL_A: state_nxt = ST_FLT_MUL_B;
      ST_FLT_MUL_B: state_nxt = ST_FLT_WAIT;
      ST_FLT_WAIT:  state_nxt = ST_FLT_TAKE;
      ST_FLT_TAKE:  state_nxt = ST_HRN_LO;
      ST_HRN_LO:    state_nxt = ST_HRN_HI;
      ST_HRN_HI:    state_nxt = ST_HRN_WAIT;
      ST_HRN_WAIT:  state_nxt = ST_HRN_RND;
      ST_HRN_RND:   state_nxt = ST_HRN_ADD;
      ST_HRN_ADD:   state_nxt = (hrn_cnt_r == HRN_OFFSET) ? ST_OUT : ST_HRN_LO;
      ST_OUT:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_raw_r  <= '0;
      prev_flt_r  <= '0;
      hrn_cnt_r   <= HRN_SQUARE;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FLT_TAKE) begin
        prev_raw_r <= raw_r;
        prev_flt_r <= filt_nxt;
        hrn_cnt_r  <= HRN_SQUARE;
      end else if (state_r == ST_HRN_ADD) begin
        hrn_cnt_r  <= hrn_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      period_r <= in_period_count;
      high_r   <= in_high_count;
    end
    if (state_r == ST_ALIGN) begin
      al_r <= al_nxt;
    end
    if (state_r == ST_RAW_TAKE) begin
      raw_r <= raw_nxt;
    end
    if (state_r == ST_FLT_TAKE) begin
      filt_r <= filt_nxt;
      hacc_r <= cfg.coef_cubic;
    end else if (state_r == ST_HRN_ADD) begin
      hacc_r <= hacc_nxt;
    end
    if (state_r == ST_HRN_RND) begin
      rnd_r <= rnd_nxt;
    end
    if (state_r == ST_OUT && out_free) begin
      out_al_r   <= al_r;
      out_flt_r  <= filt_r;
      out_comp_r <= comp_nxt;
    end
  end

`include "pwm_angle_sensor_conditioner_assert.svh"

  `PASC_ASSERT_NOW(a_ready_div_idle, in_ready, !div_sts.busy && !div_sts.done, "ready while dividing")
  `PASC_ASSERT_NOW(a_done_in_run, div_sts.done, state_r == ST_DIV_RUN, "divider done out of step")
  `PASC_ASSERT_NEXT(a_accept_drops_ready, in_valid && in_ready, !in_ready, "ready held after transfer")
  `PASC_ASSERT_NEXT(a_out_load, state_r == ST_OUT && out_free, out_valid && in_ready, "result not loaded")

endmodule

// ===== test/angle_checker.sv =====
// Checker for the angle sensor conditioner: tracks register writes, predicts and compares.
`timescale 1ns / 100ps

module angle_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [pasc_pkg::CAP_W-1:0]           in_period_count,
  input  logic [pasc_pkg::CAP_W-1:0]           in_high_count,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [pasc_pkg::AL_W-1:0]     out_aligned_count,
  input  logic signed [pasc_pkg::ANG_W-1:0]    out_filtered_angle,
  input  logic signed [pasc_pkg::ANG_W-1:0]    out_compensated_angle,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic                                 pready,
  input  logic [pasc_pkg::ADDR_W-1:0]          paddr,
  input  logic [pasc_pkg::DATA_W-1:0]          pwdata,
  output int                                   mismatches,
  output int                                   outstanding
);
  import pasc_pkg::*;

  typedef logic signed [79:0] wide_t;

  typedef struct packed {
    logic signed [AL_W-1:0]  aligned;
    logic signed [ANG_W-1:0] filtered;
    logic signed [ANG_W-1:0] compensated;
  } angle_result_t;

  localparam longint ANG_MAX  = 64'sd2097151;
  localparam longint ANG_MIN  = -64'sd2097152;
  localparam wide_t  COEF_MAX = 80'sh7FFF_FFFF_FFFF;
  localparam wide_t  COEF_MIN = -COEF_MAX - 1;

  cfg_t          regs;
  longint        last_raw;
  longint        last_filtered;
  int            fail_total;
  angle_result_t expected_q[$];

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // acc*x/256 rounded half up, plus the next coefficient, held to 48 bits
  function automatic longint horner_step(input longint acc, input longint x,
                                         input longint coef);
    wide_t p;
    p = wide_t'(acc) * wide_t'(x);
    p = ((p + 128) >>> 8) + wide_t'(coef);
    if (p > COEF_MAX) p = COEF_MAX;
    if (p < COEF_MIN) p = COEF_MIN;
    return longint'(p);
  endfunction

  function automatic angle_result_t predict_angles(input logic [CAP_W-1:0] per,
                                                   input logic [CAP_W-1:0] hi);
    angle_result_t r;
    longint cnt, lim, al, raw, filt, alpha, acc, err, comp;
    lim = longint'(regs.extension_limit);
    cnt = (longint'(hi) + 1) * FRAME_CLOCKS / (longint'(per) + 1) - ZERO_CLOCKS;
    cnt = clamp(cnt, 0, CNT_MAX);
    case (regs.align_mode)
      ALIGN_CNT_MINUS_LIM: al = cnt - lim;
      ALIGN_LIM_MINUS_CNT: al = lim - cnt;
      ALIGN_FWD_WRAP:      al = (cnt <= HALF_RES) ? cnt + SENSOR_RESOLUTION - lim : cnt - lim;
      default:             al = (cnt <= HALF_RES) ? lim - cnt : SENSOR_RESOLUTION + lim - cnt;
    endcase
    al = clamp(al, -8192, 8191);
    raw = clamp((al * RAW_SCALE + SENSOR_RESOLUTION) >>> RAW_SHIFT, ANG_MIN, ANG_MAX);
    alpha = longint'(regs.filter_alpha);
    filt = (2 * alpha * last_filtered + (65536 - alpha) * (raw + last_raw) + 65536) >>> 17;
    filt = clamp(filt, ANG_MIN, ANG_MAX);
    acc = longint'($signed(regs.coef_cubic));
    acc = horner_step(acc, filt, longint'($signed(regs.coef_square)));
    acc = horner_step(acc, filt, longint'($signed(regs.coef_linear)));
    acc = horner_step(acc, filt, longint'($signed(regs.coef_offset)));
    err = (acc + (64'sd1 <<< 31)) >>> 32;
    comp = clamp(filt + err, ANG_MIN, ANG_MAX);
    last_raw = raw;
    last_filtered = filt;
    r.aligned = al[AL_W-1:0];
    r.filtered = filt[ANG_W-1:0];
    r.compensated = comp[ANG_W-1:0];
    return r;
  endfunction

  task automatic store_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_ALIGN_MODE:      regs.align_mode = val[MODE_W-1:0];
      REG_EXTENSION_LIMIT: regs.extension_limit = val[LIM_W-1:0];
      REG_FILTER_ALPHA:    regs.filter_alpha = val[ALPHA_W-1:0];
      REG_COEF_CUBIC:      regs.coef_cubic = val[COEF_W-1:0];
      REG_COEF_SQUARE:     regs.coef_square = val[COEF_W-1:0];
      REG_COEF_LINEAR:     regs.coef_linear = val[COEF_W-1:0];
      REG_COEF_OFFSET:     regs.coef_offset = val[COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic note_failure(input string what, input angle_result_t want,
                              input angle_result_t got);
    fail_total++;
    if (fail_total <= 10)
      $display("%0t %s: aligned %0d/%0d filtered %0d/%0d compensated %0d/%0d (exp/act)",
               $time, what, $signed(want.aligned), $signed(got.aligned),
               $signed(want.filtered), $signed(got.filtered),
               $signed(want.compensated), $signed(got.compensated));
  endtask

  initial begin
    fail_total = 0;
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    angle_result_t got, want;
    if (!rst_n) begin
      regs = CFG_RESET;
      last_raw = 0;
      last_filtered = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        store_reg(paddr[ADDR_W-1:3], pwdata);
      if (in_valid && in_ready)
        expected_q.push_back(predict_angles(in_period_count, in_high_count));
      if (out_valid && out_ready) begin
        got = '{out_aligned_count, out_filtered_angle, out_compensated_angle};
        if (expected_q.size() == 0) begin
          note_failure("unexpected transfer", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) note_failure("mismatch", want, got);
        end
      end
    end
    outstanding <= expected_q.size();
    mismatches <= fail_total;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the angle sensor conditioner bench: clock, reset, stimulus, register writes, verdict.
`timescale 1ns / 100ps

module testbench;
  import pasc_pkg::*;

  localparam int               CYCLE_LIMIT = 1000000;
  localparam int               RANDOM_SETS = 8;
  localparam int               SET_ITEMS   = 135;
  localparam logic [IDX_W-1:0] REG_UNUSED  = 3'd7;
  localparam longint           COEF_MAX    = 64'sh7FFF_FFFF_FFFF;
  localparam longint           COEF_MIN    = -COEF_MAX - 1;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [CAP_W-1:0]         in_period_count;
  logic [CAP_W-1:0]         in_high_count;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [AL_W-1:0]   out_aligned_count;
  logic signed [ANG_W-1:0]  out_filtered_angle;
  logic signed [ANG_W-1:0]  out_compensated_angle;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  int                       mismatches;
  int                       outstanding;

  int                       idle_pct = 0;
  int                       stall_pct = 0;
  int                       hold_len = 0;
  int                       cycle_count = 0;

  logic [CAP_W-1:0] corner_per[6] = '{16'd0, 16'd65535, 16'd0, 16'd4118, 16'd4118, 16'd65535};
  logic [CAP_W-1:0] corner_hi[6]  = '{16'd65535, 16'd0, 16'd0, 16'd2063, 16'd2064, 16'd65535};

  pwm_angle_sensor_conditioner u_top (.*);

  angle_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_capture(input logic [CAP_W-1:0] per, input logic [CAP_W-1:0] hi);
    in_valid <= 1'b1;
    in_period_count <= per;
    in_high_count <= hi;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic random_capture();
    logic [CAP_W-1:0] per, hi;
    int               pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      per = CAP_W'($urandom) >> $urandom_range(15);
      hi = CAP_W'($urandom_range(per, 0));
    end else if (pick < 80) begin
      per = 16'd4118;
      hi = CAP_W'($urandom_range(4118));
    end else begin
      per = CAP_W'($urandom);
      hi = CAP_W'($urandom);
    end
    send_capture(per, hi);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [LIM_W-1:0] lim,
                               input logic [ALPHA_W-1:0] alpha, input longint c3,
                               input longint c2, input longint c1, input longint c0);
    write_reg(REG_ALIGN_MODE, DATA_W'(mode));
    write_reg(REG_EXTENSION_LIMIT, DATA_W'(lim));
    write_reg(REG_FILTER_ALPHA, DATA_W'(alpha));
    write_reg(REG_COEF_CUBIC, c3);
    write_reg(REG_COEF_SQUARE, c2);
    write_reg(REG_COEF_LINEAR, c1);
    write_reg(REG_COEF_OFFSET, c0);
  endtask

  function automatic longint rand_coef();
    longint v;
    v = {$urandom, $urandom};
    v = (v <<< 16) >>> 16;
    return v >>> $urandom_range(47);
  endfunction

  initial begin
    logic [MODE_W-1:0] modes[3];
    modes = '{ALIGN_CNT_MINUS_LIM, ALIGN_FWD_WRAP, ALIGN_REV_WRAP};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_period_count = '0;
    in_high_count = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners under the reset settings, then under each remaining mode
    foreach (corner_per[i]) send_capture(corner_per[i], corner_hi[i]);
    wait_drained();
    foreach (modes[m]) begin
      write_reg(REG_ALIGN_MODE, DATA_W'(modes[m]));
      foreach (corner_per[i]) send_capture(corner_per[i], corner_hi[i]);
      wait_drained();
    end
    write_reg(REG_UNUSED, {$urandom, $urandom});

    for (int s = 0; s < RANDOM_SETS; s++) begin
      case (s)
        0: apply_setting(CFG_RESET.align_mode, CFG_RESET.extension_limit,
                         CFG_RESET.filter_alpha, longint'($signed(CFG_RESET.coef_cubic)),
                         longint'($signed(CFG_RESET.coef_square)),
                         longint'($signed(CFG_RESET.coef_linear)),
                         longint'($signed(CFG_RESET.coef_offset)));
        1: apply_setting(ALIGN_CNT_MINUS_LIM, '0, '0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        2: apply_setting(ALIGN_FWD_WRAP, '1, '1, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        3: apply_setting(ALIGN_REV_WRAP, LIM_W'($urandom), ALPHA_W'($urandom),
                         rand_coef(), rand_coef(), rand_coef(), rand_coef());
        default: apply_setting(MODE_W'($urandom), LIM_W'($urandom), ALPHA_W'($urandom),
                               rand_coef(), rand_coef(), rand_coef(), rand_coef());
      endcase
      case (s % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int n = 0; n < SET_ITEMS; n++) begin
        if (s == 4 && n == 20) hold_len = 500;
        random_capture();
      end
      wait_drained();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
